/* rtl/imu_sfp_pkg.sv */
// Shared constants, types and helpers for the serial IMU frame parser.
package imu_sfp_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned WordW   = 16;
	localparam int unsigned PosW    = 4;
	localparam int unsigned DataN   = 6;
	localparam int unsigned DataIdxW = $clog2(DataN);

	localparam logic [ByteW-1:0] HDR_BYTE   = 8'h55;
	localparam logic [ByteW-1:0] TYPE_ACCEL = 8'h51;
	localparam logic [ByteW-1:0] TYPE_GYRO  = 8'h52;
	localparam logic [ByteW-1:0] TYPE_ANGLE = 8'h53;
	localparam logic [ByteW-1:0] TYPE_MAG   = 8'h54;

	localparam logic [PosW-1:0] POS_HUNT  = 4'd0;
	localparam logic [PosW-1:0] POS_TYPE  = 4'd1;
	localparam logic [PosW-1:0] POS_DATA0 = 4'd2;
	localparam logic [PosW-1:0] POS_LAST  = 4'd10;

	typedef enum logic [1:0] {
		STATUS_STORED   = 2'd0,
		STATUS_MISMATCH = 2'd1,
		STATUS_UNKNOWN  = 2'd2
	} status_t;

	function automatic logic type_known(input logic [ByteW-1:0] t);
		type_known = t inside {TYPE_ACCEL, TYPE_GYRO, TYPE_ANGLE, TYPE_MAG};
	endfunction

endpackage

/* rtl/imu_serial_frame_parser.sv */
// Serial IMU frame parser: byte input register, frame state and result register.
//
// Takes one received byte per item and hunts for the header 0x55; after a header the next
// ten bytes (type, eight data bytes, checksum) form a frame, and the checksum byte yields
// one result item with the type, the first three little-endian signed words and a status.
// A new byte is taken every cycle unless in_stall holds it; a byte passes the input register and
// then updates the position counter and 8-bit running sum; a checksum byte goes from the input
// register to the result register. A result waiting on out_stall only holds back a
// byte that would complete another frame. The checksum check enable resets to 0 (no compare).
module imu_serial_frame_parser (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic                                  cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [imu_sfp_pkg::ByteW-1:0]         rx_byte,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [1:0]                            frame_status,
	output logic [imu_sfp_pkg::ByteW-1:0]         frame_type,
	output logic signed [imu_sfp_pkg::WordW-1:0]  value_x,
	output logic signed [imu_sfp_pkg::WordW-1:0]  value_y,
	output logic signed [imu_sfp_pkg::WordW-1:0]  value_z
);

	logic                               check_en_q;
	logic                               valid_s1;
	logic [imu_sfp_pkg::ByteW-1:0]      byte_s1;
	logic [imu_sfp_pkg::PosW-1:0]       pos_q;
	logic [imu_sfp_pkg::ByteW-1:0]      sum_q;
	logic [imu_sfp_pkg::ByteW-1:0]      type_q;
	logic [imu_sfp_pkg::ByteW-1:0]      data_q [imu_sfp_pkg::DataN];
	logic                               out_valid_q;
	imu_sfp_pkg::status_t               status_q;
	logic [imu_sfp_pkg::ByteW-1:0]      type_out_q;
	logic [imu_sfp_pkg::WordW-1:0]      x_q;
	logic [imu_sfp_pkg::WordW-1:0]      y_q;
	logic [imu_sfp_pkg::WordW-1:0]      z_q;

	logic                               last_byte;
	logic                               slot_free;
	logic                               adv_s1;
	logic                               in_take;
	logic [imu_sfp_pkg::ByteW-1:0]      sum_next;
	logic [imu_sfp_pkg::PosW-1:0]       data_off;
	logic [imu_sfp_pkg::DataIdxW-1:0]   data_idx;
	imu_sfp_pkg::status_t               status_next;

	assign cfg_ready = 1'b1;

	assign last_byte = (pos_q == imu_sfp_pkg::POS_LAST);
	assign slot_free = !out_valid_q || !out_stall;
	assign adv_s1    = valid_s1 && (!last_byte || slot_free);
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_take   = in_valid && !in_stall;

	assign sum_next = sum_q + byte_s1;
	assign data_off = pos_q - imu_sfp_pkg::POS_DATA0;
	assign data_idx = data_off[imu_sfp_pkg::DataIdxW-1:0];

	always_comb begin
		if (check_en_q && (sum_q != byte_s1)) begin
			status_next = imu_sfp_pkg::STATUS_MISMATCH;
		end else if (imu_sfp_pkg::type_known(type_q)) begin
			status_next = imu_sfp_pkg::STATUS_STORED;
		end else begin
			status_next = imu_sfp_pkg::STATUS_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			check_en_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= imu_sfp_pkg::POS_HUNT;
			sum_q  <= '0;
			type_q <= '0;
		end else if (adv_s1) begin
			if (pos_q == imu_sfp_pkg::POS_HUNT || pos_q > imu_sfp_pkg::POS_LAST) begin
				if (byte_s1 == imu_sfp_pkg::HDR_BYTE) begin
					pos_q <= imu_sfp_pkg::POS_TYPE;
					sum_q <= imu_sfp_pkg::HDR_BYTE;
				end else begin
					pos_q <= imu_sfp_pkg::POS_HUNT;
				end
			end else if (last_byte) begin
				pos_q <= imu_sfp_pkg::POS_HUNT;
				sum_q <= '0;
			end else begin
				if (pos_q == imu_sfp_pkg::POS_TYPE) begin
					type_q <= byte_s1;
				end
				sum_q <= sum_next;
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pos_q >= imu_sfp_pkg::POS_DATA0
				&& data_off < imu_sfp_pkg::PosW'(imu_sfp_pkg::DataN)) begin
			data_q[data_idx] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_byte) begin
			status_q   <= status_next;
			type_out_q <= type_q;
			x_q        <= {data_q[1], data_q[0]};
			y_q        <= {data_q[3], data_q[2]};
			z_q        <= {data_q[5], data_q[4]};
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_status = status_q;
	assign frame_type   = type_out_q;
	assign value_x      = x_q;
	assign value_y      = y_q;
	assign value_z      = z_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= imu_sfp_pkg::POS_LAST)
		else $error("frame position out of range");

	a_emit_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_byte |=> out_valid_q)
		else $error("completed frame produced no result");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_byte |=> pos_q == imu_sfp_pkg::POS_HUNT && sum_q == '0)
		else $error("frame state not restarted after checksum byte");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_byte && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> status_q != 2'd3)
		else $error("invalid frame status");

endmodule

/* tb/tb_imu_serial_frame_parser.sv */
// Self-checking testbench for the serial IMU frame parser with its own byte-level frame predictor.
`timescale 1ns / 1ps

module tb_imu_serial_frame_parser;

	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int FRAMES_PER_PHASE = 45;

	typedef struct {
		imu_sfp_pkg::status_t                 status;
		logic [imu_sfp_pkg::ByteW-1:0]        kind;
		logic signed [imu_sfp_pkg::WordW-1:0] x;
		logic signed [imu_sfp_pkg::WordW-1:0] y;
		logic signed [imu_sfp_pkg::WordW-1:0] z;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [imu_sfp_pkg::ByteW-1:0] rx_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] frame_status;
	logic [imu_sfp_pkg::ByteW-1:0] frame_type;
	logic signed [imu_sfp_pkg::WordW-1:0] value_x;
	logic signed [imu_sfp_pkg::WordW-1:0] value_y;
	logic signed [imu_sfp_pkg::WordW-1:0] value_z;

	logic [imu_sfp_pkg::ByteW-1:0] pending_bytes[$];
	frame_result_t expected_frames[$];

	logic [imu_sfp_pkg::PosW-1:0]  frame_pos = imu_sfp_pkg::POS_HUNT;
	logic [imu_sfp_pkg::ByteW-1:0] frame_sum = '0;
	logic [imu_sfp_pkg::ByteW-1:0] frame_kind = '0;
	logic [imu_sfp_pkg::ByteW-1:0] frame_data[imu_sfp_pkg::DataN];
	logic                          check_enable = 1'b0;

	int items_offered = 0;
	int items_taken = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int error_count = 0;

	imu_serial_frame_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_status (frame_status),
		.frame_type   (frame_type),
		.value_x      (value_x),
		.value_y      (value_y),
		.value_z      (value_z)
	);

	always #5 clk = ~clk;

	task automatic parse_byte(input logic [imu_sfp_pkg::ByteW-1:0] b);
		frame_result_t r;
		int k;
		if (frame_pos == imu_sfp_pkg::POS_HUNT || frame_pos > imu_sfp_pkg::POS_LAST) begin
			if (b == imu_sfp_pkg::HDR_BYTE) begin
				frame_sum = imu_sfp_pkg::HDR_BYTE;
				frame_pos = imu_sfp_pkg::POS_TYPE;
			end else begin
				frame_pos = imu_sfp_pkg::POS_HUNT;
			end
		end else if (frame_pos == imu_sfp_pkg::POS_TYPE) begin
			frame_kind = b;
			frame_sum = frame_sum + b;
			frame_pos = imu_sfp_pkg::POS_DATA0;
		end else if (frame_pos < imu_sfp_pkg::POS_LAST) begin
			k = int'(frame_pos) - int'(imu_sfp_pkg::POS_DATA0);
			if (k < imu_sfp_pkg::DataN)
				frame_data[k] = b;
			frame_sum = frame_sum + b;
			frame_pos = frame_pos + 1'b1;
		end else begin
			if (check_enable && frame_sum != b)
				r.status = imu_sfp_pkg::STATUS_MISMATCH;
			else if (frame_kind == imu_sfp_pkg::TYPE_ACCEL
					|| frame_kind == imu_sfp_pkg::TYPE_GYRO
					|| frame_kind == imu_sfp_pkg::TYPE_ANGLE
					|| frame_kind == imu_sfp_pkg::TYPE_MAG)
				r.status = imu_sfp_pkg::STATUS_STORED;
			else
				r.status = imu_sfp_pkg::STATUS_UNKNOWN;
			r.kind = frame_kind;
			r.x = {frame_data[1], frame_data[0]};
			r.y = {frame_data[3], frame_data[2]};
			r.z = {frame_data[5], frame_data[4]};
			expected_frames.push_back(r);
			frame_pos = imu_sfp_pkg::POS_HUNT;
			frame_sum = '0;
		end
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// data holds the eight data bytes, least significant byte first on the link
	task automatic push_frame(input logic [imu_sfp_pkg::ByteW-1:0] kind,
			input logic [63:0] data, input bit good_sum);
		logic [imu_sfp_pkg::ByteW-1:0] sum;
		sum = imu_sfp_pkg::HDR_BYTE + kind;
		pending_bytes.push_back(imu_sfp_pkg::HDR_BYTE);
		pending_bytes.push_back(kind);
		for (int i = 0; i < 8; i++) begin
			sum = sum + data[8*i +: 8];
			pending_bytes.push_back(data[8*i +: 8]);
		end
		if (good_sum)
			pending_bytes.push_back(sum);
		else
			pending_bytes.push_back(sum + 8'($urandom_range(1, 255)));
	endtask

	task automatic push_random_frame();
		logic [imu_sfp_pkg::ByteW-1:0] kind;
		logic [63:0] data;
		int pick;
		pick = $urandom_range(99);
		if (pick < 85) begin
			case ($urandom_range(7))
				0: kind = imu_sfp_pkg::TYPE_ACCEL;
				1: kind = imu_sfp_pkg::TYPE_GYRO;
				2: kind = imu_sfp_pkg::TYPE_ANGLE;
				3: kind = imu_sfp_pkg::TYPE_MAG;
				4: kind = imu_sfp_pkg::TYPE_ACCEL;
				5: kind = imu_sfp_pkg::TYPE_GYRO;
				default: kind = 8'($urandom_range(255));
			endcase
			case ($urandom_range(9))
				0: data = {4{16'h8000}};
				1: data = {4{16'h7fff}};
				default: data = {$urandom, $urandom};
			endcase
			push_frame(kind, data, $urandom_range(99) < 80);
		end else if (pick < 93) begin
			repeat ($urandom_range(1, 4))
				pending_bytes.push_back(8'($urandom_range(255)));
		end else begin
			pending_bytes.push_back(imu_sfp_pkg::HDR_BYTE);
			repeat ($urandom_range(1, 9))
				pending_bytes.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic write_check_enable(input logic value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		check_enable = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// advance the predictor on every accepted byte
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			parse_byte(rx_byte);
			items_taken++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || items_taken == items_offered)) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				rx_byte <= pending_bytes.pop_front();
				items_offered++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left == 0 && holds_served != hold_requests) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_frames.size() == 0) begin
				$error("frame result with no frame pending");
				error_count++;
			end else begin
				want = expected_frames.pop_front();
				compare_field("frame_status", int'(want.status), int'(frame_status));
				compare_field("frame_type", int'(want.kind), int'(frame_type));
				compare_field("value_x", int'(want.x), int'(value_x));
				compare_field("value_y", int'(want.y), int'(value_y));
				compare_field("value_z", int'(want.z), int'(value_z));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			send_idle_pct = (phase == 1) ? 53 : (phase == 3) ? 12 : 0;
			stall_pct = (phase == 2) ? 53 : (phase == 3) ? 12 : 0;
			write_check_enable(phase == 1 || phase == 2);
			if (phase == 0) begin
				pending_bytes.push_back(8'h00);
				pending_bytes.push_back(8'hff);
				push_frame(imu_sfp_pkg::TYPE_ACCEL, 64'h0000_ffff_7fff_8000, 1'b0);
				push_frame(imu_sfp_pkg::HDR_BYTE, {8{imu_sfp_pkg::HDR_BYTE}}, 1'b1);
				drain();
				hold_requests++;
			end
			for (int n = 0; n < FRAMES_PER_PHASE; n++)
				push_random_frame();
		end
		drain();

		if (error_count == 0 && expected_frames.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
